// ----- sv/smdf_pkg.sv -----
// smdf_pkg: shared types and codes for the slot map with deferred free.
// Used by slot_map_deferred_free. No dependencies.
package smdf_pkg;

  localparam int RID_W   = 16;
  localparam int FRAME_W = 62;
  localparam int SAFE_W  = FRAME_W + 1;

  localparam logic [2:0] CMD_ALLOC   = 3'd0;
  localparam logic [2:0] CMD_BATCH   = 3'd1;
  localparam logic [2:0] CMD_RESOLVE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP  = 3'd3;
  localparam logic [2:0] CMD_RETIRE  = 3'd4;
  localparam logic [2:0] CMD_COLLECT = 3'd5;
  localparam logic [2:0] CMD_COMPACT = 3'd6;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_FRAMES   = 2'd1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RB_RD,
    S_RB_CHK,
    S_EXEC,
    S_B_EL,
    S_ID,
    S_B_FIN,
    S_LK,
    S_C_RD,
    S_C_CHK,
    S_C_MV,
    S_S_RDI,
    S_S_V,
    S_S_RDJ,
    S_S_CMP,
    S_P_RD,
    S_P_CHK
  } state_t;

endpackage

// ----- sv/smdf_ram.sv -----
// smdf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module smdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/slot_map_deferred_free.sv -----
// slot_map_deferred_free: top level, command sequencer and map/list memories.
// Depends on smdf_pkg and smdf_ram.
//
// After reset the block runs a clearing pass over the id and slot maps with
// busy high; configuration writes are taken throughout. A command is taken
// when start is high and busy low. One shared sequencer walks single-write,
// single-read memories for alloc, resolve, retire and slot lookup; a batch
// writes its elements one at a time and is rolled back, published element
// by published element, when a bad element or an interrupting command
// arrives; collect examines quarantine entries and frees the ones it does
// not skip; compact is an insertion sort of the free list, followed by
// peeling slots off its end.
// Results appear in the cycle after they are produced, one word per strobe,
// and cannot be held off.
module slot_map_deferred_free #(
  parameter int ID_SPACE  = 4096,
  parameter int MAX_SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            cmd,
  input  logic [15:0]           obj_id,
  input  logic [9:0]            slot_index,
  input  logic [61:0]           frame,
  input  logic [10:0]           batch_count,
  input  logic [5:0]            max_report,
  output logic                  strobe,
  output logic                  status,
  output logic [9:0]            slot,
  output logic [15:0]           obj_id_res,
  output logic [10:0]           count,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [10:0]           cfg_data
);

  import smdf_pkg::*;

  localparam int SW   = $clog2(MAX_SLOTS);
  localparam int IW   = $clog2(ID_SPACE);
  localparam int CLRN = (ID_SPACE > MAX_SLOTS) ? ID_SPACE : MAX_SLOTS;
  localparam int CW   = $clog2(CLRN);
  localparam int QW   = SW + RID_W + SAFE_W;
  localparam logic [10:0]   MaxLim  = 11'(MAX_SLOTS);
  localparam logic [16:0]   IdLim   = 17'(ID_SPACE);
  localparam logic [CW:0]   ClrIdN  = (CW+1)'(ID_SPACE);
  localparam logic [CW:0]   ClrSlN  = (CW+1)'(MAX_SLOTS);
  localparam logic [CW-1:0] ClrLast = CW'(CLRN - 1);

  state_t state, state_next;

  logic [2:0]         cmd_r;
  logic [15:0]        rid_r;
  logic [9:0]         sidx_r;
  logic [61:0]        frame_r;
  logic [10:0]        bcnt_r;
  logic [5:0]         maxr_r;
  logic [10:0]        cap;
  logic [4:0]         fif;
  logic [10:0]        fc, hw, qc;
  logic [10:0]        b_base, b_seen, b_total;
  logic               b_failed;
  logic [10:0]        rb_j;
  state_t             rb_ret;
  logic [CW-1:0]      clr;
  logic [10:0]        ci;
  logic [6:0]         cn;
  logic [10:0]        si, sj;
  logic [SW-1:0]      sv;
  logic [10:0]        hw_start;

  logic               idm_we, slm_we, flm_we, qm_we;
  logic [IW-1:0]      idm_waddr, idm_raddr;
  logic [SW:0]        idm_wdata, idm_rdata;
  logic [SW-1:0]      slm_waddr, slm_raddr;
  logic [16:0]        slm_wdata, slm_rdata;
  logic [SW-1:0]      flm_waddr, flm_raddr;
  logic [SW-1:0]      flm_wdata, flm_rdata;
  logic [SW-1:0]      qm_waddr, qm_raddr;
  logic [QW-1:0]      qm_wdata, qm_rdata;

  logic               fire, r_st, r_last;
  logic [9:0]         r_sl;
  logic [15:0]        r_rid;
  logic [10:0]        r_cnt;

  logic               rid_bad, id_v, intr, b_over, b_slot_bad, rb_s_ok, lk_ok;
  logic               a_fail, c_skip, s_gt, p_match, b_end;
  logic [SW-1:0]      id_s, a_slot, q_slot;
  logic [15:0]        q_id;
  logic [SAFE_W-1:0]  q_safe, new_safe;
  logic [11:0]        b_slot, rb_s;

  smdf_ram #(.WIDTH(SW + 1), .DEPTH(ID_SPACE)) u_idm (
    .clk(clk), .we(idm_we), .waddr(idm_waddr), .wdata(idm_wdata),
    .raddr(idm_raddr), .rdata(idm_rdata)
  );
  smdf_ram #(.WIDTH(17), .DEPTH(MAX_SLOTS)) u_slm (
    .clk(clk), .we(slm_we), .waddr(slm_waddr), .wdata(slm_wdata),
    .raddr(slm_raddr), .rdata(slm_rdata)
  );
  smdf_ram #(.WIDTH(SW), .DEPTH(MAX_SLOTS)) u_flm (
    .clk(clk), .we(flm_we), .waddr(flm_waddr), .wdata(flm_wdata),
    .raddr(flm_raddr), .rdata(flm_rdata)
  );
  smdf_ram #(.WIDTH(QW), .DEPTH(MAX_SLOTS)) u_qm (
    .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
    .raddr(qm_raddr), .rdata(qm_rdata)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // shared decode
  always_comb begin
    rid_bad    = {1'b0, rid_r} >= IdLim;
    id_v       = idm_rdata[SW];
    id_s       = idm_rdata[SW-1:0];
    intr       = (cmd != CMD_BATCH) && (b_seen != '0);
    b_over     = ({1'b0, hw} + {1'b0, bcnt_r}) > {1'b0, cap};
    b_slot     = {1'b0, b_base} + {1'b0, b_seen};
    b_slot_bad = b_slot >= {1'b0, MaxLim};
    rb_s       = {1'b0, b_base} + {1'b0, rb_j};
    rb_s_ok    = rb_s < {1'b0, MaxLim};
    lk_ok      = ({1'b0, sidx_r} < cap) && ({1'b0, sidx_r} < MaxLim);
    a_fail     = id_v || ((fc == '0) && (hw >= cap));
    a_slot     = (fc != '0) ? flm_rdata : hw[SW-1:0];
    q_safe     = qm_rdata[SAFE_W-1:0];
    q_id       = qm_rdata[SAFE_W+RID_W-1:SAFE_W];
    q_slot     = qm_rdata[QW-1:SAFE_W+RID_W];
    new_safe   = {1'b0, frame_r} + SAFE_W'(fif);
    c_skip     = (q_safe > {1'b0, frame_r}) || (cn >= {1'b0, maxr_r}) || (fc >= MaxLim);
    s_gt       = flm_rdata > sv;
    p_match    = 11'(flm_rdata) == (hw - 11'd1);
    b_end      = ({1'b0, b_seen} + 12'd1) >= {1'b0, b_total};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr == ClrLast) state_next = S_IDLE;
      S_IDLE: begin
        if (start) state_next = (intr && !b_failed) ? S_RB_RD : S_EXEC;
      end
      S_RB_RD: begin
        if (rb_j < b_seen) state_next = rb_s_ok ? S_RB_CHK : S_RB_RD;
        else state_next = rb_ret;
      end
      S_RB_CHK: state_next = S_RB_RD;
      S_EXEC: begin
        case (cmd_r)
          CMD_ALLOC, CMD_RESOLVE, CMD_RETIRE: state_next = rid_bad ? S_IDLE : S_ID;
          CMD_BATCH: state_next = (b_seen == '0 && bcnt_r == '0) ? S_IDLE : S_B_EL;
          CMD_LOOKUP: state_next = lk_ok ? S_LK : S_IDLE;
          CMD_COLLECT: state_next = S_C_RD;
          CMD_COMPACT: state_next = S_S_RDI;
          default: state_next = S_IDLE;
        endcase
      end
      S_B_EL: begin
        if (b_failed) state_next = S_B_FIN;
        else if (rid_bad || b_slot_bad) state_next = S_RB_RD;
        else state_next = S_ID;
      end
      S_ID: begin
        if (cmd_r == CMD_BATCH) state_next = id_v ? S_RB_RD : S_B_FIN;
        else state_next = S_IDLE;
      end
      S_B_FIN: state_next = S_IDLE;
      S_LK: state_next = S_IDLE;
      S_C_RD: state_next = (ci < qc) ? S_C_CHK : S_IDLE;
      S_C_CHK: state_next = c_skip ? S_C_RD : S_C_MV;
      S_C_MV: state_next = S_C_RD;
      S_S_RDI: state_next = (si < fc) ? S_S_V : S_P_RD;
      S_S_V: state_next = S_S_RDJ;
      S_S_RDJ: state_next = (sj != '0) ? S_S_CMP : S_S_RDI;
      S_S_CMP: state_next = s_gt ? S_S_RDJ : S_S_RDI;
      S_P_RD: state_next = (fc != '0 && hw != '0) ? S_P_CHK : S_IDLE;
      S_P_CHK: state_next = p_match ? S_P_RD : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and results
  always_comb begin
    idm_we = 1'b0; idm_waddr = rid_r[IW-1:0]; idm_wdata = '0;
    idm_raddr = rid_r[IW-1:0];
    slm_we = 1'b0; slm_waddr = '0; slm_wdata = '0;
    slm_raddr = (state == S_RB_RD) ? rb_s[SW-1:0] : sidx_r[SW-1:0];
    flm_we = 1'b0; flm_waddr = fc[SW-1:0]; flm_wdata = '0;
    flm_raddr = fc[SW-1:0] - SW'(1);
    qm_we = 1'b0; qm_waddr = ci[SW-1:0]; qm_wdata = '0;
    qm_raddr = (state == S_C_CHK) ? (qc[SW-1:0] - SW'(1)) : ci[SW-1:0];
    fire = 1'b0; r_st = 1'b0; r_sl = '0; r_rid = '0; r_cnt = '0; r_last = 1'b1;
    case (state)
      S_S_RDI: flm_raddr = si[SW-1:0];
      S_S_RDJ: flm_raddr = sj[SW-1:0] - SW'(1);
      default: ;
    endcase
    case (state)
      S_CLEAR: begin
        idm_we    = {1'b0, clr} < ClrIdN;
        idm_waddr = clr[IW-1:0];
        slm_we    = {1'b0, clr} < ClrSlN;
        slm_waddr = clr[SW-1:0];
      end
      S_RB_CHK: begin
        idm_we    = slm_rdata[16];
        idm_waddr = slm_rdata[IW-1:0];
        slm_we    = slm_rdata[16];
        slm_waddr = rb_s[SW-1:0];
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_ALLOC, CMD_RESOLVE, CMD_RETIRE: begin
            fire = rid_bad;
            r_st = 1'b1;
          end
          CMD_BATCH: begin
            fire = (b_seen == '0) && (bcnt_r == '0);
            r_st = 1'b1;
          end
          CMD_LOOKUP: begin
            fire = !lk_ok;
            r_st = 1'b1;
          end
          CMD_COLLECT, CMD_COMPACT: ;
          default: begin
            fire = 1'b1;
            r_st = 1'b1;
          end
        endcase
      end
      S_ID: begin
        case (cmd_r)
          CMD_ALLOC: begin
            fire      = 1'b1;
            r_st      = a_fail;
            r_sl      = a_fail ? '0 : 10'(a_slot);
            idm_we    = !a_fail;
            idm_wdata = {1'b1, a_slot};
            slm_we    = !a_fail;
            slm_waddr = a_slot;
            slm_wdata = {1'b1, rid_r};
          end
          CMD_RESOLVE: begin
            fire = 1'b1;
            r_st = !id_v;
            r_sl = id_v ? 10'(id_s) : '0;
          end
          CMD_RETIRE: begin
            fire      = 1'b1;
            r_st      = !id_v;
            r_sl      = id_v ? 10'(id_s) : '0;
            idm_we    = id_v;
            idm_wdata = {1'b0, id_s};
            slm_we    = id_v;
            slm_waddr = id_s;
            qm_we     = id_v && (qc < MaxLim);
            qm_waddr  = qc[SW-1:0];
            qm_wdata  = {id_s, rid_r, new_safe};
          end
          CMD_BATCH: begin
            idm_we    = !id_v;
            idm_wdata = {1'b1, b_slot[SW-1:0]};
            slm_we    = !id_v;
            slm_waddr = b_slot[SW-1:0];
            slm_wdata = {1'b1, rid_r};
          end
          default: ;
        endcase
      end
      S_B_FIN: begin
        fire = b_end;
        r_st = b_failed;
        r_sl = b_failed ? '0 : b_base[9:0];
      end
      S_LK: begin
        fire  = 1'b1;
        r_st  = !slm_rdata[16];
        r_rid = slm_rdata[16] ? slm_rdata[15:0] : '0;
      end
      S_C_RD: begin
        fire  = !(ci < qc);
        r_cnt = 11'(cn);
      end
      S_C_CHK: begin
        fire      = !c_skip;
        r_sl      = 10'(q_slot);
        r_rid     = q_id;
        r_last    = 1'b0;
        flm_we    = !c_skip;
        flm_wdata = q_slot;
      end
      S_C_MV: begin
        qm_we    = 1'b1;
        qm_wdata = qm_rdata;
      end
      S_S_RDJ: begin
        flm_we    = (sj == '0);
        flm_waddr = '0;
        flm_wdata = sv;
      end
      S_S_CMP: begin
        flm_we    = 1'b1;
        flm_waddr = sj[SW-1:0];
        flm_wdata = s_gt ? flm_rdata : sv;
      end
      S_P_RD: begin
        fire  = !(fc != '0 && hw != '0);
        r_cnt = hw_start - hw;
      end
      S_P_CHK: begin
        fire  = !p_match;
        r_cnt = hw_start - hw;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      cap      <= MaxLim;
      fif      <= 5'd2;
      fc       <= '0;
      hw       <= '0;
      qc       <= '0;
      b_base   <= '0;
      b_seen   <= '0;
      b_total  <= '0;
      b_failed <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= fire;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CAPACITY: if (cfg_data > cap) cap <= (cfg_data > MaxLim) ? MaxLim : cfg_data;
          CFG_FRAMES: fif <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: clr <= clr + CW'(1);
        S_IDLE: begin
          if (start && intr) begin
            if (b_failed) begin
              b_seen   <= '0;
              b_total  <= '0;
              b_failed <= 1'b0;
            end else begin
              rb_j   <= '0;
              rb_ret <= S_EXEC;
            end
          end
        end
        S_RB_RD: begin
          if (rb_j < b_seen) begin
            if (!rb_s_ok) rb_j <= rb_j + 11'd1;
          end else if (rb_ret == S_EXEC) begin
            b_seen   <= '0;
            b_total  <= '0;
            b_failed <= 1'b0;
          end
        end
        S_RB_CHK: rb_j <= rb_j + 11'd1;
        S_EXEC: begin
          case (cmd_r)
            CMD_BATCH: begin
              if (b_seen == '0 && bcnt_r != '0) begin
                b_total  <= bcnt_r;
                b_base   <= hw;
                b_failed <= b_over;
              end
            end
            CMD_COLLECT: begin
              ci <= '0;
              cn <= '0;
            end
            CMD_COMPACT: begin
              si       <= 11'd1;
              hw_start <= hw;
            end
            default: ;
          endcase
        end
        S_B_EL: begin
          if (!b_failed && (rid_bad || b_slot_bad)) begin
            b_failed <= 1'b1;
            rb_j     <= '0;
            rb_ret   <= S_B_FIN;
          end
        end
        S_ID: begin
          case (cmd_r)
            CMD_ALLOC: begin
              if (!a_fail) begin
                if (fc != '0) fc <= fc - 11'd1;
                else hw <= hw + 11'd1;
              end
            end
            CMD_RETIRE: if (id_v && qc < MaxLim) qc <= qc + 11'd1;
            CMD_BATCH: begin
              if (id_v) begin
                b_failed <= 1'b1;
                rb_j     <= '0;
                rb_ret   <= S_B_FIN;
              end
            end
            default: ;
          endcase
        end
        S_B_FIN: begin
          if (b_end) begin
            if (!b_failed) hw <= b_base + b_total;
            b_seen   <= '0;
            b_total  <= '0;
            b_failed <= 1'b0;
          end else begin
            b_seen <= b_seen + 11'd1;
          end
        end
        S_C_CHK: begin
          if (c_skip) begin
            ci <= ci + 11'd1;
          end else begin
            fc <= fc + 11'd1;
            cn <= cn + 7'd1;
            qc <= qc - 11'd1;
          end
        end
        S_S_V: begin
          sv <= flm_rdata;
          sj <= si;
        end
        S_S_RDJ: if (sj == '0) si <= si + 11'd1;
        S_S_CMP: begin
          if (s_gt) sj <= sj - 11'd1;
          else si <= si + 11'd1;
        end
        S_P_CHK: begin
          if (p_match) begin
            fc <= fc - 11'd1;
            hw <= hw - 11'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_r   <= cmd;
      rid_r   <= obj_id;
      sidx_r  <= slot_index;
      frame_r <= frame;
      bcnt_r  <= batch_count;
      maxr_r  <= max_report;
    end
    status     <= r_st;
    slot       <= r_sl;
    obj_id_res <= r_rid;
    count      <= r_cnt;
    last       <= r_last;
  end

  a_hw_cap: assert property (@(posedge clk) disable iff (rst) hw <= cap)
    else $error("high-water above capacity");
  a_fc_max: assert property (@(posedge clk) disable iff (rst) fc <= MaxLim)
    else $error("free list overflow");
  a_qc_max: assert property (@(posedge clk) disable iff (rst) qc <= MaxLim)
    else $error("quarantine overflow");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command taken without going busy");
  a_clr_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |=> !strobe)
    else $error("result during clearing pass");

endmodule
